>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/isl_pkg.sv
// Package: sizes, operation and status codes, cell command type.
`timescale 1ns / 1ps

package isl_pkg;

	localparam int LIST_DEPTH  = 128;
	localparam int ENTRY_WIDTH = 32;

	// Fixed field widths of the channels
	localparam int OP_W    = 3;
	localparam int POS_W   = 8;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 8;

	localparam int IDX_W   = $clog2(LIST_DEPTH);
	localparam int COUNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_AT   = 3'd1,
		OP_INS_TAIL = 3'd2,
		OP_REM_HEAD = 3'd3,
		OP_REM_AT   = 3'd4,
		OP_REM_TAIL = 3'd5,
		OP_READ     = 3'd6
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] at;
	} cell_cmd_t;

	typedef logic [ENTRY_WIDTH-1:0] entry_t;

endpackage

>>> rtl/isl_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface isl_req_if;
	import isl_pkg::*;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] entry_value;

	modport source (output valid, output op, output position, output entry_value, input ready);
	modport sink (input valid, input op, input position, input entry_value, output ready);
endinterface

interface isl_rsp_if;
	import isl_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value_out;
	logic               value_valid;
	logic [STAT_W-1:0]  status;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, output value_out, output value_valid, output status,
		output entry_count, input ready);
	modport sink (input valid, input value_out, input value_valid, input status,
		input entry_count, output ready);
endinterface

>>> rtl/isl_cell.sv
// One list slot: holds an entry and shifts with its neighbors on insert or remove.
`timescale 1ns / 1ps

module isl_cell (
	input  logic                     clk,
	input  isl_pkg::cell_cmd_t       cmd,
	input  logic [isl_pkg::IDX_W-1:0] my_idx,
	input  logic [isl_pkg::IDX_W-1:0] rd_idx,
	input  isl_pkg::entry_t          word,
	input  isl_pkg::entry_t          left_data,
	input  isl_pkg::entry_t          right_data,
	output isl_pkg::entry_t          data,
	output isl_pkg::entry_t          rd_data
);
	import isl_pkg::*;

	entry_t data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (my_idx > cmd.at) begin
					data_q <= left_data;
				end else if (my_idx == cmd.at) begin
					data_q <= word;
				end
			end
			CELL_REMOVE: begin
				if (my_idx >= cmd.at) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	// Masked contribution to the row-wide OR read
	assign rd_data = (my_idx == rd_idx) ? data_q : '0;

endmodule

>>> rtl/isl_chain.sv
// Row of list cells with neighbor links and the OR-combined read port.
`timescale 1ns / 1ps

module isl_chain (
	input  logic                      clk,
	input  isl_pkg::cell_cmd_t        cmd,
	input  isl_pkg::entry_t           word,
	input  logic [isl_pkg::IDX_W-1:0] rd_idx,
	output isl_pkg::entry_t           rd_data
);
	import isl_pkg::*;

	entry_t cell_data [LIST_DEPTH];
	entry_t cell_rd   [LIST_DEPTH];

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		entry_t left_w;
		entry_t right_w;

		// End cells feed back own data; the first cell's left link is unused
		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == LIST_DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		isl_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.my_idx     (IDX_W'(i)),
			.rd_idx     (rd_idx),
			.word       (word),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

endmodule

>>> rtl/indexed_shift_list_unit.sv
// A request's response is registered on acceptance. Throughput: one transaction per
// cycle unless a pending response is stalled; every cell of the row shifts in the same
// cycle and reads come through a single OR combine across the row.
// Reset: arst_n clears the entry count and the response valid; cell contents are
// undefined until written and are never observed before that.
`timescale 1ns / 1ps

module indexed_shift_list_unit (
	input  logic      clk,
	input  logic      arst_n,
	isl_req_if.sink   req,
	isl_rsp_if.source rsp
);
	import isl_pkg::*;
	`include "assert_macros.svh"

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               rsp_valid_q;
	logic [VALUE_W-1:0] value_out_q;
	logic               value_valid_q;
	status_t            status_q;
	logic [CNT_W-1:0]   entry_count_q;

	logic               accept;
	logic [CMP_W-1:0]   pos_c;
	logic [CMP_W-1:0]   cnt_c;
	logic [CMP_W-1:0]   at_c;
	status_t            status_d;
	logic               value_valid_d;
	cell_op_t           cell_op_d;
	cell_cmd_t          cmd;
	logic [IDX_W-1:0]   rd_idx;
	entry_t             rd_data;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_c = CMP_W'(req.position);
	assign cnt_c = CMP_W'(count_q);

	always_comb begin
		at_c          = '0;
		status_d      = ST_OK;
		value_valid_d = 1'b0;
		cell_op_d     = CELL_HOLD;
		count_next    = count_q;
		case (req.op)
			OP_INS_HEAD, OP_INS_AT, OP_INS_TAIL: begin
				if (req.op == OP_INS_AT) begin
					at_c = pos_c;
				end else if (req.op == OP_INS_TAIL) begin
					at_c = cnt_c;
				end
				if (count_q == COUNT_W'(LIST_DEPTH)) begin
					status_d = ST_FULL;
				end else if (at_c > cnt_c) begin
					status_d = ST_RANGE;
				end else begin
					cell_op_d  = CELL_INSERT;
					count_next = count_q + COUNT_W'(1);
				end
			end
			OP_REM_HEAD, OP_REM_AT, OP_REM_TAIL: begin
				if (req.op == OP_REM_AT) begin
					at_c = pos_c;
				end else if (req.op == OP_REM_TAIL) begin
					at_c = cnt_c - CMP_W'(1);
				end
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (at_c >= cnt_c) begin
					status_d = ST_RANGE;
				end else begin
					cell_op_d     = CELL_REMOVE;
					value_valid_d = 1'b1;
					count_next    = count_q - COUNT_W'(1);
				end
			end
			OP_READ: begin
				at_c = pos_c;
				if (pos_c >= cnt_c) begin
					status_d = ST_RANGE;
				end else begin
					value_valid_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// at_c is below the depth whenever it is used, so the truncation is exact
	assign rd_idx = at_c[IDX_W-1:0];
	assign cmd.op = accept ? cell_op_d : CELL_HOLD;
	assign cmd.at = rd_idx;

	isl_chain u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.word    (ENTRY_WIDTH'(req.entry_value)),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q   <= value_valid_d ? VALUE_W'(rd_data) : '0;
			value_valid_q <= value_valid_d;
			status_q      <= status_d;
			entry_count_q <= CNT_W'(count_next);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.value_out   = value_out_q;
	assign rsp.value_valid = value_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= COUNT_W'(LIST_DEPTH), "count above depth")
	`ASSERT_ALWAYS(a_value_ok, clk, arst_n, !(rsp_valid_q && value_valid_q) || status_q == ST_OK, "value with error status")
	`ASSERT_NEXT(a_count_hold, clk, arst_n, !accept, $stable(count_q), "count changed without transaction")
	`ASSERT_NEXT(a_ins_count, clk, arst_n, accept && cell_op_d == CELL_INSERT, count_q == $past(count_q) + COUNT_W'(1), "insert did not grow count")

endmodule

>>> tb/tb_indexed_shift_list_unit.sv
// Testbench for indexed_shift_list_unit: directed table plus random list traffic, self-checked.
`timescale 1ns / 1ps

module tb_indexed_shift_list_unit;
	import isl_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 3'd7;	// unused code, must be a no-op
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [VALUE_W-1:0] value_out;
		logic               value_valid;
		status_t            status;
		logic [CNT_W-1:0]   entry_count;
	} list_reply_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] word;
		logic               typed;
		list_reply_t        want;
	} script_row_t;

	typedef enum {FILL_RUN, DRAIN_RUN, MIXED_RUN} run_kind_t;

	localparam list_reply_t NO_CHECK = '{32'h0, 1'b0, ST_OK, 8'd0};
	localparam int SCRIPT_LEN = 24;

	// Rows with a typed reply are checked against that reply; the others use the predictor.
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_REM_HEAD, 8'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_EMPTY, 8'd0}},
		'{OP_REM_AT,   8'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_EMPTY, 8'd0}},
		'{OP_REM_TAIL, 8'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_EMPTY, 8'd0}},
		'{OP_READ,     8'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd0}},
		'{OP_INS_AT,   8'd1,   32'h1234_5678, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd0}},
		'{OP_INS_HEAD, 8'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK,    8'd1}},
		'{OP_INS_TAIL, 8'd0,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_OK,    8'd2}},
		'{OP_INS_AT,   8'd2,   32'hA5A5_A5A5, 1'b1, '{32'h0, 1'b0, ST_OK,    8'd3}},
		'{OP_INS_AT,   8'd1,   32'h5A5A_5A5A, 1'b0, NO_CHECK},
		'{OP_INS_HEAD, 8'd0,   32'h0000_0001, 1'b0, NO_CHECK},
		'{OP_READ,     8'd0,   32'h0000_0000, 1'b1, '{32'h1, 1'b1, ST_OK,    8'd5}},
		'{OP_READ,     8'd5,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_READ,     8'd255, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_INS_AT,   8'd255, 32'hDEAD_BEEF, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_INS_AT,   8'd6,   32'hDEAD_BEEF, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_REM_AT,   8'd5,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_REM_AT,   8'd255, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, ST_RANGE, 8'd5}},
		'{OP_REM_AT,   8'd2,   32'h0000_0000, 1'b0, NO_CHECK},
		'{OP_NONE,     8'd255, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, ST_OK,    8'd4}},
		'{OP_REM_TAIL, 8'd0,   32'h0000_0000, 1'b0, NO_CHECK},
		'{OP_REM_HEAD, 8'd0,   32'h0000_0000, 1'b0, NO_CHECK},
		'{OP_READ,     8'd1,   32'h0000_0000, 1'b0, NO_CHECK},
		'{OP_INS_AT,   8'd0,   32'h8000_0000, 1'b0, NO_CHECK},
		'{OP_REM_AT,   8'd0,   32'h0000_0000, 1'b0, NO_CHECK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	isl_req_if req_bus();
	isl_rsp_if rsp_bus();

	indexed_shift_list_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Behavioral copy of the list
	entry_t      list_mem [LIST_DEPTH];
	int unsigned list_len;

	list_reply_t awaited_replies [$];
	int          fault_count;
	int          burst_left;
	int          stall_pct;
	int          stall_cycle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_reply_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
		logic [VALUE_W-1:0] word);
		list_reply_t r;
		int unsigned at;
		int unsigned k;
		r.value_out   = '0;
		r.value_valid = 1'b0;
		r.status      = ST_OK;
		case (op)
			OP_INS_HEAD, OP_INS_AT, OP_INS_TAIL: begin
				at = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? list_len : pos;
				if (list_len >= LIST_DEPTH)
					r.status = ST_FULL;	// full wins over a bad position
				else if (at > list_len)
					r.status = ST_RANGE;
				else begin
					for (k = list_len; k > at; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[at] = word;
					list_len++;
				end
			end
			OP_REM_HEAD, OP_REM_AT, OP_REM_TAIL: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else begin
					at = (op == OP_REM_HEAD) ? 0 : (op == OP_REM_TAIL) ? list_len - 1 : pos;
					if (at >= list_len)
						r.status = ST_RANGE;
					else begin
						r.value_out   = list_mem[at];
						r.value_valid = 1'b1;
						list_len--;
						for (k = at; k < list_len; k++)
							list_mem[k] = list_mem[k+1];
					end
				end
			end
			OP_READ: begin
				if (pos >= list_len)
					r.status = ST_RANGE;
				else begin
					r.value_out   = list_mem[pos];
					r.value_valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(list_len);
		return r;
	endfunction

	// Sender: bursts of random length separated by random gaps, some gaps zero.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
		input logic [VALUE_W-1:0] word, input logic typed, input list_reply_t want);
		int gap;
		list_reply_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				req_bus.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		req_bus.valid       = 1'b1;
		req_bus.op          = op;
		req_bus.position    = pos;
		req_bus.entry_value = word;
		do @(posedge clk); while (!req_bus.ready);
		predicted = apply_list_op(op, pos, word);
		awaited_replies.push_back(typed ? want : predicted);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		fault_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// Receiver: stall rate is redrawn now and then from a set of levels, including no stalls at all.
	always @(negedge clk) begin
		if (stall_cycle == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 15;
				2: stall_pct = 50;
				default: stall_pct = 80;
			endcase
			stall_cycle = 200;
		end
		stall_cycle--;
		rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_replies.size() == 0) begin
				fault_count++;
				$display("%0t: response transaction with none expected, actual value %0h status %0d",
					$time, rsp_bus.value_out, rsp_bus.status);
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_bus.value_out !== want.value_out)
					report_mismatch("value_out", want.value_out, rsp_bus.value_out);
				if (rsp_bus.value_valid !== want.value_valid)
					report_mismatch("value_valid", want.value_valid, rsp_bus.value_valid);
				if (rsp_bus.status !== want.status)
					report_mismatch("status", want.status, rsp_bus.status);
				if (rsp_bus.entry_count !== want.entry_count)
					report_mismatch("entry_count", want.entry_count, rsp_bus.entry_count);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** indexed_shift_list_unit: FAILED **");
		$finish;
	end

	initial begin
		run_kind_t        run_kind;
		int               run_left;
		int               n;
		int               roll;
		int               ins_cut;
		int               rem_cut;
		int unsigned      limit;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VALUE_W-1:0] word;

		req_bus.valid       = 1'b0;
		req_bus.op          = '0;
		req_bus.position    = '0;
		req_bus.entry_value = '0;
		rsp_bus.ready       = 1'b0;
		list_len    = 0;
		fault_count = 0;
		burst_left  = 0;
		stall_pct   = 0;
		stall_cycle = 0;
		run_left    = 0;
		run_kind    = MIXED_RUN;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < SCRIPT_LEN; n++)
			send_request(SCRIPT[n].op, SCRIPT[n].pos, SCRIPT[n].word, SCRIPT[n].typed,
				SCRIPT[n].want);

		// Runs biased toward filling or draining, or mixed, so the list reaches full and empty.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (run_left == 0) begin
				run_kind = run_kind_t'($urandom_range(0, 2));
				run_left = $urandom_range(60, 260);
			end
			run_left--;
			ins_cut = (run_kind == FILL_RUN) ? 78 : (run_kind == DRAIN_RUN) ? 15 : 33;
			rem_cut = ins_cut + ((run_kind == FILL_RUN) ? 12 : (run_kind == DRAIN_RUN) ? 75 : 33);
			roll = $urandom_range(0, 99);
			if (roll == 99)
				op = OP_NONE;
			else if (roll < ins_cut) begin
				case ($urandom_range(0, 3))
					0: op = OP_INS_HEAD;
					1: op = OP_INS_TAIL;
					default: op = OP_INS_AT;
				endcase
			end else if (roll < rem_cut) begin
				case ($urandom_range(0, 3))
					0: op = OP_REM_HEAD;
					1: op = OP_REM_TAIL;
					default: op = OP_REM_AT;
				endcase
			end else
				op = OP_READ;

			if (op == OP_INS_HEAD || op == OP_INS_AT || op == OP_INS_TAIL)
				limit = list_len;
			else
				limit = (list_len == 0) ? 0 : list_len - 1;
			roll = $urandom_range(0, 9);
			if (roll < 7)
				pos = POS_W'($urandom_range(0, limit));
			else if (roll == 7)
				pos = POS_W'(list_len);	// one past the last entry
			else if (roll == 8)
				pos = POS_W'($urandom_range(0, 255));
			else
				pos = POS_W'(list_len + 1);

			roll = $urandom_range(0, 7);
			word = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : 32'($urandom);
			send_request(op, pos, word, 1'b0, NO_CHECK);
		end

		@(negedge clk);
		req_bus.valid = 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("** indexed_shift_list_unit: PASSED **");
		else
			$display("** indexed_shift_list_unit: FAILED **");
		$finish;
	end

endmodule
